>>> design/euler_rpy_to_rotation_matrix_top_defines.svh
// Assertion macros for the roll-pitch-yaw to rotation matrix block.
// Included by the top level; no other dependencies.
`ifndef EULER_RPY_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`define EULER_RPY_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ERM_ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define ERM_ASSERT_NEVER(label, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("forbidden condition seen");
`else
`define ERM_ASSERT_IMPLIES(label, a, b)
`define ERM_ASSERT_NEVER(label, a)
`endif
`endif

>>> design/erm_pkg.sv
// Shared constants, types and fixed-point helpers for the rotation matrix block.
// No dependencies.
package erm_pkg;

  localparam int IN_W = 25;
  localparam int OUT_W = 32;
  localparam int W = 34;
  localparam int WORK_FRAC = 30;
  localparam int STEPS = 30;
  localparam int LANE_LAT = STEPS + 4;
  localparam int MERGE_LAT = 3;
  localparam int LAT = LANE_LAT + MERGE_LAT;

  localparam logic signed [25:0] FULL = 26'sd23592960;
  localparam logic signed [25:0] HALF = 26'sd11796480;
  localparam logic signed [25:0] QUARTER = 26'sd5898240;
  localparam logic [26:0] DEG_TO_RAD = 27'd74961321;
  localparam logic signed [W-1:0] GAIN = 34'sd652032874;
  localparam logic signed [W-1:0] ONE = 34'sd1073741824;

  typedef logic signed [W-1:0] w_t;

  function automatic w_t atan_q30(input int i);
    w_t t;
    case (i)
      0: t = 34'sd843314857;
      1: t = 34'sd497837829;
      2: t = 34'sd263043837;
      3: t = 34'sd133525159;
      4: t = 34'sd67021687;
      5: t = 34'sd33543516;
      6: t = 34'sd16775851;
      7: t = 34'sd8388437;
      8: t = 34'sd4194283;
      9: t = 34'sd2097149;
      default: t = w_t'(34'sd1 <<< (WORK_FRAC - i));
    endcase
    return t;
  endfunction

  function automatic w_t mul_q30(input w_t a, input w_t b);
    logic signed [2*W-1:0] p;
    p = (2*W)'(a) * (2*W)'(b) + (2*W)'(64'sd536870912);
    return w_t'(p >>> WORK_FRAC);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input w_t v);
    w_t s;
    s = v;
    if (v > ONE) s = ONE;
    if (v < -ONE) s = -ONE;
    return s[OUT_W-1:0];
  endfunction

endpackage

>>> design/erm_lane.sv
// One angle lane: range reduction, degree to radian scaling and a pipelined CORDIC.
// Depends on erm_pkg.
module erm_lane (
  input  logic                              clk,
  input  logic signed [erm_pkg::IN_W-1:0]   deg,
  output erm_pkg::w_t                       sin_q,
  output erm_pkg::w_t                       cos_q
);

  logic signed [25:0] d, r0, r1;
  logic               fl0;
  logic [22:0]        mag1;
  logic               neg1, flip1;
  logic [49:0]        prod2;
  logic               neg2, flip2;
  logic [31:0]        zm;
  erm_pkg::w_t        x [0:erm_pkg::STEPS];
  erm_pkg::w_t        y [0:erm_pkg::STEPS];
  erm_pkg::w_t        z [0:erm_pkg::STEPS];
  logic               flp [0:erm_pkg::STEPS];

  always_comb begin
    d = {deg[erm_pkg::IN_W-1], deg};
    r0 = d;
    if (d < 0) r0 = d + erm_pkg::FULL;
    if (r0 >= erm_pkg::HALF) r0 = r0 - erm_pkg::FULL;
    r1 = r0;
    fl0 = 1'b0;
    if (r0 > erm_pkg::QUARTER) begin
      r1 = r0 - erm_pkg::HALF;
      fl0 = 1'b1;
    end else if (r0 < -erm_pkg::QUARTER) begin
      r1 = r0 + erm_pkg::HALF;
      fl0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    neg1 <= r1 < 0;
    mag1 <= (r1 < 0) ? 23'(-r1) : 23'(r1);
    flip1 <= fl0;
    prod2 <= 50'(mag1) * 50'(erm_pkg::DEG_TO_RAD);
    neg2 <= neg1;
    flip2 <= flip1;
    z[0] <= neg2 ? -erm_pkg::w_t'({2'b00, zm}) : erm_pkg::w_t'({2'b00, zm});
    flp[0] <= flip2;
  end

  assign zm = 32'((prod2 + 50'd131072) >> 18);
  assign x[0] = erm_pkg::GAIN;
  assign y[0] = '0;

  for (genvar i = 0; i < erm_pkg::STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (z[i] >= 0) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - erm_pkg::atan_q30(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + erm_pkg::atan_q30(i);
      end
      flp[i+1] <= flp[i];
    end
  end

  always_ff @(posedge clk) begin
    sin_q <= flp[erm_pkg::STEPS] ? -y[erm_pkg::STEPS] : y[erm_pkg::STEPS];
    cos_q <= flp[erm_pkg::STEPS] ? -x[erm_pkg::STEPS] : x[erm_pkg::STEPS];
  end

endmodule

>>> design/erm_merge.sv
// Merging stage: combines the three lanes' sine and cosine into the nine entries.
// Depends on erm_pkg.
module erm_merge (
  input  logic                               clk,
  input  erm_pkg::w_t                        sx, cx, sy, cy, sz, cz,
  output logic signed [erm_pkg::OUT_W-1:0]   e [0:8]
);

  erm_pkg::w_t czsy, szsy, czcy, szcy, cysx, cycx, szcx, szsx, czcx, czsx;
  erm_pkg::w_t sx1, cx1, nsy;
  erm_pkg::w_t m [0:8];

  always_ff @(posedge clk) begin
    czsy <= erm_pkg::mul_q30(cz, sy);
    szsy <= erm_pkg::mul_q30(sz, sy);
    czcy <= erm_pkg::mul_q30(cz, cy);
    szcy <= erm_pkg::mul_q30(sz, cy);
    cysx <= erm_pkg::mul_q30(cy, sx);
    cycx <= erm_pkg::mul_q30(cy, cx);
    szcx <= erm_pkg::mul_q30(sz, cx);
    szsx <= erm_pkg::mul_q30(sz, sx);
    czcx <= erm_pkg::mul_q30(cz, cx);
    czsx <= erm_pkg::mul_q30(cz, sx);
    sx1 <= sx;
    cx1 <= cx;
    nsy <= -sy;
  end

  always_ff @(posedge clk) begin
    m[0] <= czcy;
    m[1] <= erm_pkg::mul_q30(czsy, sx1) - szcx;
    m[2] <= erm_pkg::mul_q30(czsy, cx1) + szsx;
    m[3] <= szcy;
    m[4] <= erm_pkg::mul_q30(szsy, sx1) + czcx;
    m[5] <= erm_pkg::mul_q30(szsy, cx1) - czsx;
    m[6] <= nsy;
    m[7] <= cysx;
    m[8] <= cycx;
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    always_ff @(posedge clk) begin
      e[k] <= erm_pkg::sat(m[k]);
    end
  end

endmodule

>>> design/euler_rpy_to_rotation_matrix_top.sv
// Top level: roll-pitch-yaw angles in, rotation matrix entries out.
// Depends on erm_pkg, erm_lane, erm_merge and the defines header.
//
//   channel   handshake     payload
//   request   start, busy   roll_deg, pitch_deg, yaw_deg (Q9.16 degrees)
//   result    done          r00 .. r22 (Q2.30)
//
// One request per cycle; busy is never raised. Each angle lane registers range
// reduction, the scaling multiply, 30 CORDIC stages and a sign fix; the merge
// registers two multiply ranks and saturation. Reset clears only the valid
// pipeline. done is high for one cycle per request and is not stalled.
`include "euler_rpy_to_rotation_matrix_top_defines.svh"
module euler_rpy_to_rotation_matrix_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [erm_pkg::IN_W-1:0]   roll_deg,
  input  logic signed [erm_pkg::IN_W-1:0]   pitch_deg,
  input  logic signed [erm_pkg::IN_W-1:0]   yaw_deg,
  output logic                              done,
  output logic signed [erm_pkg::OUT_W-1:0]  r00, r01, r02,
  output logic signed [erm_pkg::OUT_W-1:0]  r10, r11, r12,
  output logic signed [erm_pkg::OUT_W-1:0]  r20, r21, r22
);

  erm_pkg::w_t sx, cx, sy, cy, sz, cz;
  logic signed [erm_pkg::OUT_W-1:0] e [0:8];
  logic [erm_pkg::LAT-1:0] vpipe;
  logic accept;

  assign busy = 1'b0;
  assign accept = start && !busy;

  erm_lane u_roll  (.clk(clk), .deg(roll_deg),  .sin_q(sx), .cos_q(cx));
  erm_lane u_pitch (.clk(clk), .deg(pitch_deg), .sin_q(sy), .cos_q(cy));
  erm_lane u_yaw   (.clk(clk), .deg(yaw_deg),   .sin_q(sz), .cos_q(cz));

  erm_merge u_merge (
    .clk(clk), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz), .e(e)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[erm_pkg::LAT-2:0], accept};
    end
  end

  assign done = vpipe[erm_pkg::LAT-1];
  assign r00 = e[0];
  assign r01 = e[1];
  assign r02 = e[2];
  assign r10 = e[3];
  assign r11 = e[4];
  assign r12 = e[5];
  assign r20 = e[6];
  assign r21 = e[7];
  assign r22 = e[8];

  `ERM_ASSERT_IMPLIES(a_done_has_request, done, $past(accept, erm_pkg::LAT))
  `ERM_ASSERT_IMPLIES(a_r00_range, done, (r00 <= 32'sd1073741824) && (r00 >= -32'sd1073741824))
  `ERM_ASSERT_IMPLIES(a_r20_range, done, (r20 <= 32'sd1073741824) && (r20 >= -32'sd1073741824))
  `ERM_ASSERT_NEVER(a_never_busy, busy)

endmodule

>>> bench/testbench.sv
// Self-checking bench for euler_rpy_to_rotation_matrix_top: drives pose requests,
// predicts each rotation matrix in fixed point and compares every entry.
// Depends on erm_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [erm_pkg::IN_W-1:0] ang_t;
  typedef struct {
    ang_t roll;
    ang_t pitch;
    ang_t yaw;
  } pose_t;
  typedef logic [8:0][erm_pkg::OUT_W-1:0] rot_t;

  localparam longint DEG_UNIT = 64'sd65536;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ang_t roll_deg = '0, pitch_deg = '0, yaw_deg = '0;
  logic done;
  logic signed [erm_pkg::OUT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  pose_t poses[$];
  rot_t rot_expected[$];
  int req_idx = 0;
  int cycles = 0;
  int errors = 0;
  bit drained_once = 0;

  euler_rpy_to_rotation_matrix_top dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void add_pose(pose_t p);
    poses.insert(poses.size(), p);
  endfunction

  function automatic void add_expected(rot_t m);
    rot_expected.insert(rot_expected.size(), m);
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void angle_sincos(longint deg, output longint s, output longint c);
    longint full, half, quarter, r, mag, z, x, y, t, dx, dy;
    bit flip, neg;
    full = 360 * DEG_UNIT;
    half = 180 * DEG_UNIT;
    quarter = 90 * DEG_UNIT;
    flip = 0;
    r = deg % full;
    if (r < 0) r += full;
    if (r >= half) r -= full;
    if (r > quarter) begin
      r -= half;
      flip = 1;
    end else if (r < -quarter) begin
      r += half;
      flip = 1;
    end
    neg = r < 0;
    mag = neg ? -r : r;
    mag = (mag * 64'sd74961321 + (64'sd1 <<< 17)) >>> 18;
    z = neg ? -mag : mag;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      case (i)
        0: t = 843314857;
        1: t = 497837829;
        2: t = 263043837;
        3: t = 133525159;
        4: t = 67021687;
        5: t = 33543516;
        6: t = 16775851;
        7: t = 8388437;
        8: t = 4194283;
        9: t = 2097149;
        default: t = 64'sd1 <<< (30 - i);
      endcase
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic logic [erm_pkg::OUT_W-1:0] clamp_unit(longint v);
    longint one;
    one = 64'sd1 <<< 30;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[erm_pkg::OUT_W-1:0];
  endfunction

  function automatic rot_t rotation_of(pose_t p);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    rot_t m;
    angle_sincos(longint'(p.roll), sx, cx);
    angle_sincos(longint'(p.pitch), sy, cy);
    angle_sincos(longint'(p.yaw), sz, cz);
    czsy = fmul(cz, sy);
    szsy = fmul(sz, sy);
    m[0] = clamp_unit(fmul(cz, cy));
    m[1] = clamp_unit(fmul(czsy, sx) - fmul(sz, cx));
    m[2] = clamp_unit(fmul(czsy, cx) + fmul(sz, sx));
    m[3] = clamp_unit(fmul(sz, cy));
    m[4] = clamp_unit(fmul(szsy, sx) + fmul(cz, cx));
    m[5] = clamp_unit(fmul(szsy, cx) - fmul(cz, sx));
    m[6] = clamp_unit(-sy);
    m[7] = clamp_unit(fmul(cy, sx));
    m[8] = clamp_unit(fmul(cy, cx));
    return m;
  endfunction

  function automatic ang_t rand_angle();
    ang_t v;
    case ($urandom_range(3))
      0, 1: v = ang_t'($urandom);
      2: v = ang_t'($signed($urandom_range(4)) - 2) * ang_t'(90 * DEG_UNIT)
             + ang_t'($signed($urandom_range(6)) - 3);
      default: v = $urandom_range(1) ? ang_t'(25'sh0FFFFFF - $urandom_range(3))
                                     : ang_t'(25'sh1000000 + $urandom_range(3));
    endcase
    return v;
  endfunction

  // directed, corner and random poses; all checked against the predictor
  initial begin
    longint dirs[20];
    pose_t p;
    dirs = '{0, 90, -90, 180, -180, 45, -45, 270, -270, 135, 225, 30, 60,
             89, 91, 179, 181, 256, -256, 1};
    foreach (dirs[i]) begin
      p.roll = ang_t'(dirs[i] * DEG_UNIT);
      p.pitch = ang_t'(dirs[(i + 7) % 20] * DEG_UNIT);
      p.yaw = ang_t'(dirs[(i + 13) % 20] * DEG_UNIT);
      add_pose(p);
    end
    add_pose('{25'sh0FFFFFF, 25'sh1000000, 25'sh1555555});
    add_pose('{25'sh1000000, 25'sh0FFFFFF, 25'sh0AAAAAA});
    add_pose('{25'sh1FFFFFF, 25'sh0000001, 25'sh1FFFFFF});
    add_pose('{ang_t'(90 * DEG_UNIT + 1), ang_t'(-90 * DEG_UNIT - 1),
               ang_t'(180 * DEG_UNIT - 1)});
    for (int i = 0; i < 1200; i++) begin
      p.roll = rand_angle();
      p.pitch = rand_angle();
      p.yaw = rand_angle();
      add_pose(p);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    bit idle;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        add_expected(rotation_of('{roll_deg, pitch_deg, yaw_deg}));
        req_idx++;
      end
      idle = !(req_idx > 400 && req_idx < 700) && ($urandom_range(99) < 13);
      if (req_idx == 600 && !drained_once) begin
        idle = 1;
        if (rot_expected.size() == 0) drained_once = 1;
      end
      if (req_idx < poses.size() && !idle) begin
        start <= 1'b1;
        roll_deg <= poses[req_idx].roll;
        pitch_deg <= poses[req_idx].pitch;
        yaw_deg <= poses[req_idx].yaw;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rot_t got, want;
    if (!rst && done) begin
      got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
      if (rot_expected.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        errors++;
      end else begin
        want = rot_expected.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== want[k]) begin
            $display("%0t: r%0d%0d expected %0d got %0d", $time, k / 3, k % 3,
                     $signed(want[k]), $signed(got[k]));
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    wait (!rst && poses.size() > 0 && req_idx == poses.size());
    while (rot_expected.size() != 0) @(posedge clk);
    repeat (erm_pkg::LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
